>>> rtl/bmfp_pkg.sv
// Shared types and constants for the bitmap font binary parser.
package bmfp_pkg;

	localparam int unsigned RecordBytes = 20;
	localparam int unsigned RecIdxW     = $clog2(RecordBytes);

	localparam logic [7:0] BLOCK_COMMON = 8'd2;
	localparam logic [7:0] BLOCK_CHARS  = 8'd4;
	localparam logic [7:0] BLOCK_KERN   = 8'd5;

	localparam logic [7:0] MAGIC [4] = '{8'd66, 8'd77, 8'd70, 8'd3};

	typedef enum logic [2:0] {
		KIND_COMMON = 3'd0,
		KIND_GLYPH  = 3'd1,
		KIND_BADHDR = 3'd2,
		KIND_KERN   = 3'd3,
		KIND_TRUNC  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_ID     = 2'd1,
		PH_SIZE   = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	typedef struct packed {
		logic               vld;
		kind_t              kind;
		logic        [31:0] char_id;
		logic        [15:0] atlas_x;
		logic        [15:0] atlas_y;
		logic        [15:0] glyph_width;
		logic        [15:0] glyph_height;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
		logic signed [15:0] x_advance;
		logic        [15:0] line_pitch;
		logic        [15:0] baseline;
	} result_t;

endpackage

>>> rtl/bmfp_core.sv
// Parser state and per-byte decode: header check, block framing, field capture.
module bmfp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              end_of_file,
	output bmfp_pkg::result_t res
);
	import bmfp_pkg::*;

	phase_t              phase_q, phase_n;
	logic [1:0]          hdr_cnt_q, hdr_cnt_n;
	logic [7:0]          block_id_q, block_id_n;
	logic [31:0]         block_size_q, block_size_n;
	logic [31:0]         body_off_q, body_off_n;
	logic [RecIdxW-1:0]  rec_pos_q, rec_pos_n;
	logic                err_q, err_n;
	logic [7:0]          rec_q [RecordBytes];
	logic                rec_we;
	logic [RecIdxW-1:0]  rec_idx;
	logic [RecIdxW-1:0]  gpos;
	logic [31:0]         size_upd;

	always_comb begin
		phase_n      = phase_q;
		hdr_cnt_n    = hdr_cnt_q;
		block_id_n   = block_id_q;
		block_size_n = block_size_q;
		body_off_n   = body_off_q;
		rec_pos_n    = rec_pos_q;
		err_n        = err_q;
		rec_we       = 1'b0;
		rec_idx      = rec_pos_q;
		res          = '0;
		res.kind     = KIND_COMMON;
		gpos         = (rec_pos_q >= RecIdxW'(RecordBytes)) ? '0 : rec_pos_q;

		unique case (hdr_cnt_q)
			2'd0: size_upd = {block_size_q[31:8], data_byte};
			2'd1: size_upd = {block_size_q[31:16], data_byte, block_size_q[7:0]};
			2'd2: size_upd = {block_size_q[31:24], data_byte, block_size_q[15:0]};
			default: size_upd = {data_byte, block_size_q[23:0]};
		endcase

		if (!err_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (data_byte != MAGIC[hdr_cnt_q]) begin
						err_n    = 1'b1;
						res.vld  = 1'b1;
						res.kind = KIND_BADHDR;
					end else if (hdr_cnt_q == 2'd3) begin
						hdr_cnt_n = '0;
						phase_n   = PH_ID;
					end else begin
						hdr_cnt_n = hdr_cnt_q + 2'd1;
					end
				end
				PH_ID: begin
					block_id_n   = data_byte;
					block_size_n = '0;
					hdr_cnt_n    = '0;
					phase_n      = PH_SIZE;
				end
				PH_SIZE: begin
					block_size_n = size_upd;
					if (hdr_cnt_q == 2'd3) begin
						hdr_cnt_n  = '0;
						body_off_n = '0;
						rec_pos_n  = '0;
						phase_n    = (size_upd == '0) ? PH_ID : PH_BODY;
						if (block_id_q == BLOCK_KERN) begin
							res.vld  = 1'b1;
							res.kind = KIND_KERN;
						end
					end else begin
						hdr_cnt_n = hdr_cnt_q + 2'd1;
					end
				end
				default: begin
					if (block_id_q == BLOCK_COMMON) begin
						if (rec_pos_q < RecIdxW'(4)) begin
							rec_we  = 1'b1;
							rec_idx = rec_pos_q;
							if (rec_pos_q == RecIdxW'(3)) begin
								res.vld         = 1'b1;
								res.kind        = KIND_COMMON;
								res.line_pitch  = {rec_q[1], rec_q[0]};
								res.baseline    = {data_byte, rec_q[2]};
							end
							rec_pos_n = rec_pos_q + RecIdxW'(1);
						end
					end else if (block_id_q == BLOCK_CHARS) begin
						rec_we  = 1'b1;
						rec_idx = gpos;
						if (gpos == RecIdxW'(RecordBytes - 1)) begin
							res.vld          = 1'b1;
							res.kind         = KIND_GLYPH;
							res.char_id      = {rec_q[3], rec_q[2], rec_q[1], rec_q[0]};
							res.atlas_x      = {rec_q[5], rec_q[4]};
							res.atlas_y      = {rec_q[7], rec_q[6]};
							res.glyph_width  = {rec_q[9], rec_q[8]};
							res.glyph_height = {rec_q[11], rec_q[10]};
							res.x_offset     = {rec_q[13], rec_q[12]};
							res.y_offset     = {rec_q[15], rec_q[14]};
							res.x_advance    = {rec_q[17], rec_q[16]};
							rec_pos_n        = '0;
						end else begin
							rec_pos_n = gpos + RecIdxW'(1);
						end
					end
					body_off_n = body_off_q + 32'd1;
					if (body_off_n >= block_size_q) begin
						phase_n    = PH_ID;
						body_off_n = '0;
						rec_pos_n  = '0;
					end
				end
			endcase
		end

		if (end_of_file) begin
			if (!res.vld && !err_n && phase_n != PH_ID) begin
				res.vld  = 1'b1;
				res.kind = KIND_TRUNC;
			end
			phase_n      = PH_HEADER;
			hdr_cnt_n    = '0;
			block_id_n   = '0;
			block_size_n = '0;
			body_off_n   = '0;
			rec_pos_n    = '0;
			err_n        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_cnt_q    <= '0;
			block_id_q   <= '0;
			block_size_q <= '0;
			body_off_q   <= '0;
			rec_pos_q    <= '0;
			err_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_n;
			hdr_cnt_q    <= hdr_cnt_n;
			block_id_q   <= block_id_n;
			block_size_q <= block_size_n;
			body_off_q   <= body_off_n;
			rec_pos_q    <= rec_pos_n;
			err_q        <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && rec_we) begin
			rec_q[rec_idx] <= data_byte;
		end
	end

endmodule

>>> rtl/bitmap_font_binary_parser.sv
// Top level of the bitmap font binary parser: input stage, decode core, result register.
//
// Usage:
//   Slave side takes one font file byte per request in s_tdata, with s_tlast
//   marking the final byte of the file. Master side delivers at most one
//   result per byte: kind code in m_tuser, all record
//   fields in m_tdata (fields not belonging to the kind are zero).
//   A result reaches m_tvalid through two registers: its byte is held in the
//   input register, then decoded into the result register.
//   Throughput: one byte per cycle unless a pending result is held by low m_tready,
//   set by the single decode stage between the input register and the result
//   register; bytes giving no result occupy no output slot.
//   When m_tready is low with a result pending, the decode stage holds and
//   s_tready drops once the input register is also full; no data is lost.
//   Reset (arst_n low) empties both registers and returns the parser to the
//   header state; the last byte of a file returns the parser to the header state after it is decoded.
//   A bad magic reports once, then bytes are swallowed until end of file.
module bitmap_font_binary_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// char_id[31:0], atlas_x, atlas_y, glyph_width, glyph_height,
	// x_offset, y_offset, x_advance, line_pitch, baseline (16 bits each)
	output logic [175:0] m_tdata,
	output logic [2:0]   m_tuser    // kind
);
	import bmfp_pkg::*;

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      eof_s1;
	logic      advance;
	result_t   res;
	result_t   res_q;
	logic      out_vld_q;

	assign advance  = valid_s1 && (!out_vld_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	bmfp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= res.vld;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {res_q.baseline, res_q.line_pitch, res_q.x_advance, res_q.y_offset,
		res_q.x_offset, res_q.glyph_height, res_q.glyph_width, res_q.atlas_y,
		res_q.atlas_x, res_q.char_id};

endmodule

>>> sim/bitmap_font_binary_parser_test.sv
// Testbench for bitmap_font_binary_parser: directed and random font files in, decoded records checked.
module bitmap_font_binary_parser_test;
	import bmfp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} file_byte_t;

	typedef struct packed {
		kind_t              kind;
		logic        [31:0] char_id;
		logic        [15:0] atlas_x;
		logic        [15:0] atlas_y;
		logic        [15:0] glyph_width;
		logic        [15:0] glyph_height;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
		logic signed [15:0] x_advance;
		logic        [15:0] line_pitch;
		logic        [15:0] baseline;
	} font_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [175:0] m_tdata;
	logic [2:0]   m_tuser;

	file_byte_t   file_bytes [$];
	file_byte_t   next_byte;
	font_result_t due_results [$];
	logic [7:0]   fbuf [$];
	int unsigned  cyc = 0;
	int unsigned  mismatches = 0;

	// parser shadow state
	phase_t       ph;
	int unsigned  hdr_cnt;
	logic [7:0]   blk_id;
	logic [31:0]  blk_size;
	logic [31:0]  body_off;
	int unsigned  rec_pos;
	logic [7:0]   rec [RecordBytes];
	logic         bad_file;

	bitmap_font_binary_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	always @(posedge clk) cyc <= cyc + 1;

	function automatic bit take_break();
		return (cyc < 300 || cyc >= 800) && $urandom_range(99) < 21;
	endfunction

	task automatic reset_parser();
		ph = PH_HEADER;
		hdr_cnt = 0;
		blk_id = '0;
		blk_size = '0;
		body_off = '0;
		rec_pos = 0;
		bad_file = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic eof);
		font_result_t r;
		bit got;
		r = '0;
		got = 0;
		if (!bad_file) begin
			case (ph)
				PH_HEADER: begin
					if (b != MAGIC[hdr_cnt]) begin
						bad_file = 1'b1;
						r.kind = KIND_BADHDR;
						got = 1;
					end else if (hdr_cnt == 3) begin
						hdr_cnt = 0;
						ph = PH_ID;
					end else begin
						hdr_cnt++;
					end
				end
				PH_ID: begin
					blk_id = b;
					blk_size = '0;
					hdr_cnt = 0;
					ph = PH_SIZE;
				end
				PH_SIZE: begin
					blk_size = blk_size | (32'(b) << (8 * hdr_cnt));
					if (hdr_cnt == 3) begin
						hdr_cnt = 0;
						body_off = '0;
						rec_pos = 0;
						ph = (blk_size == 0) ? PH_ID : PH_BODY;
						if (blk_id == BLOCK_KERN) begin
							r.kind = KIND_KERN;
							got = 1;
						end
					end else begin
						hdr_cnt++;
					end
				end
				PH_BODY: begin
					if (blk_id == BLOCK_COMMON) begin
						if (rec_pos < 4) begin
							rec[rec_pos] = b;
							if (rec_pos == 3) begin
								r.kind = KIND_COMMON;
								r.line_pitch = {rec[1], rec[0]};
								r.baseline = {rec[3], rec[2]};
								got = 1;
							end
							rec_pos++;
						end
					end else if (blk_id == BLOCK_CHARS) begin
						if (rec_pos >= RecordBytes)
							rec_pos = 0;
						rec[rec_pos] = b;
						if (rec_pos == RecordBytes - 1) begin
							r.kind = KIND_GLYPH;
							r.char_id = {rec[3], rec[2], rec[1], rec[0]};
							r.atlas_x = {rec[5], rec[4]};
							r.atlas_y = {rec[7], rec[6]};
							r.glyph_width = {rec[9], rec[8]};
							r.glyph_height = {rec[11], rec[10]};
							r.x_offset = {rec[13], rec[12]};
							r.y_offset = {rec[15], rec[14]};
							r.x_advance = {rec[17], rec[16]};
							got = 1;
							rec_pos = 0;
						end else begin
							rec_pos++;
						end
					end
					body_off++;
					if (body_off >= blk_size) begin
						ph = PH_ID;
						body_off = '0;
						rec_pos = 0;
					end
				end
			endcase
		end
		if (eof) begin
			if (!got && !bad_file && ph != PH_ID) begin
				r = '0;
				r.kind = KIND_TRUNC;
				got = 1;
			end
			reset_parser();
		end
		if (got)
			due_results.insert(due_results.size(), r);
	endtask

	task automatic flag_mismatch(input string msg);
		$display("ERROR at cycle %0d: %s", cyc, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] seen, input logic [31:0] want);
		if (seen !== want)
			flag_mismatch($sformatf("%s got %0h, expected %0h", name, seen, want));
	endtask

	task automatic check_result();
		font_result_t w;
		if (due_results.size() == 0) begin
			flag_mismatch($sformatf("unexpected result, kind %0d", m_tuser));
			return;
		end
		w = due_results.pop_front();
		check_field("kind", 32'(m_tuser), 32'(w.kind));
		check_field("char_id", m_tdata[31:0], w.char_id);
		check_field("atlas_x", 32'(m_tdata[47:32]), 32'(w.atlas_x));
		check_field("atlas_y", 32'(m_tdata[63:48]), 32'(w.atlas_y));
		check_field("glyph_width", 32'(m_tdata[79:64]), 32'(w.glyph_width));
		check_field("glyph_height", 32'(m_tdata[95:80]), 32'(w.glyph_height));
		check_field("x_offset", 32'(m_tdata[111:96]), 32'($unsigned(w.x_offset)));
		check_field("y_offset", 32'(m_tdata[127:112]), 32'($unsigned(w.y_offset)));
		check_field("x_advance", 32'(m_tdata[143:128]), 32'($unsigned(w.x_advance)));
		check_field("line_pitch", 32'(m_tdata[159:144]), 32'(w.line_pitch));
		check_field("baseline", 32'(m_tdata[175:160]), 32'(w.baseline));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (file_bytes.size() != 0 && !take_break()) begin
					next_byte = file_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_byte.data;
					s_tlast <= next_byte.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			m_tready <= !take_break();
		end
	end

	task automatic put_magic();
		for (int i = 0; i < 4; i++)
			fbuf.insert(fbuf.size(), MAGIC[i]);
	endtask

	task automatic put_head(input logic [7:0] id, input logic [31:0] size);
		fbuf.insert(fbuf.size(), id);
		for (int i = 0; i < 4; i++)
			fbuf.insert(fbuf.size(), size[8*i +: 8]);
	endtask

	task automatic put_rand_bytes(input int unsigned n);
		logic [7:0] edge_vals [4];
		edge_vals = '{8'h00, 8'hFF, 8'h7F, 8'h80};
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0)
				fbuf.insert(fbuf.size(), edge_vals[$urandom_range(3)]);
			else
				fbuf.insert(fbuf.size(), 8'($urandom));
		end
	endtask

	// push the first keep bytes of fbuf as one file, last byte flagged
	task automatic emit_file(input int unsigned keep);
		file_byte_t fb;
		for (int unsigned i = 0; i < keep; i++) begin
			fb.data = fbuf[i];
			fb.last = (i == keep - 1);
			file_bytes.insert(file_bytes.size(), fb);
		end
		fbuf.delete();
	endtask

	task automatic make_random_file();
		int unsigned mode, nblk, sel, sz, keep;
		bit cut;
		mode = $urandom_range(99);
		cut = 0;
		if (mode < 78) begin
			put_magic();
			nblk = $urandom_range(5);
			for (int unsigned k = 0; k < nblk && !cut; k++) begin
				sel = $urandom_range(9);
				if (sel < 2) begin
					if ($urandom_range(3) == 0)
						sz = $urandom_range(3);
					else if ($urandom_range(9) < 7)
						sz = 4;
					else
						sz = $urandom_range(5, 9);
					put_head(BLOCK_COMMON, sz);
				end else if (sel < 5) begin
					sz = $urandom_range(3) * RecordBytes;
					if ($urandom_range(2) == 0)
						sz += $urandom_range(1, RecordBytes - 1);
					put_head(BLOCK_CHARS, sz);
				end else if (sel < 7) begin
					sz = $urandom_range(4);
					put_head(BLOCK_KERN, sz);
				end else if (sel < 9) begin
					sz = $urandom_range(6);
					put_head(8'($urandom), sz);
				end else begin
					// huge size: body runs to end of file
					sz = $urandom_range(30);
					put_head(8'($urandom), $urandom | 32'h0100_0000);
					cut = 1;
				end
				put_rand_bytes(sz);
			end
			keep = fbuf.size();
			if (!cut && $urandom_range(3) == 0)
				keep = $urandom_range(1, fbuf.size());
		end else if (mode < 90) begin
			put_magic();
			sel = $urandom_range(3);
			fbuf[sel] = fbuf[sel] ^ 8'($urandom_range(1, 255));
			put_rand_bytes($urandom_range(8));
			keep = fbuf.size();
		end else begin
			put_rand_bytes($urandom_range(1, 10));
			keep = fbuf.size();
		end
		emit_file(keep);
	endtask

	initial begin
		reset_parser();
		// common metrics, then a kerning block ending the file on its size
		put_magic();
		put_head(BLOCK_COMMON, 4);
		fbuf.insert(fbuf.size(), 8'hFF);
		fbuf.insert(fbuf.size(), 8'hFF);
		fbuf.insert(fbuf.size(), 8'h00);
		fbuf.insert(fbuf.size(), 8'h00);
		put_head(BLOCK_KERN, 0);
		emit_file(fbuf.size());
		// bad magic on the third byte, rest ignored
		fbuf.insert(fbuf.size(), MAGIC[0]);
		fbuf.insert(fbuf.size(), MAGIC[1]);
		fbuf.insert(fbuf.size(), 8'h58);
		fbuf.insert(fbuf.size(), 8'h00);
		emit_file(fbuf.size());
		// file ends inside the header
		fbuf.insert(fbuf.size(), MAGIC[0]);
		emit_file(1);
		while (file_bytes.size() < 1150)
			make_random_file();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (file_bytes.size() == 0);
		@(posedge clk);
		while (s_tvalid)
			@(posedge clk);
		wait (due_results.size() == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("bitmap_font_binary_parser_test passed");
		else
			$display("bitmap_font_binary_parser_test failed");
		$finish;
	end

	initial begin
		#2400000;
		$display("bitmap_font_binary_parser_test failed");
		$finish;
	end

endmodule
